/* rtl/rlpd_pkg.sv */
package rlpd_pkg;

	localparam int LEN_WIDTH  = 32;
	localparam int GRP_W      = $clog2(LEN_WIDTH + 1);
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [GRP_W-1:0] FIRST_GROUP_W = GRP_W'(2);
	localparam logic [3:0]       BYTE_BITS     = 4'd8;
	localparam logic [3:0]       MAX_OFFSET    = 4'd8;

	localparam logic ST_OK       = 1'b0;
	localparam logic ST_OVERFLOW = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_BODY
	} phase_t;

	typedef struct packed {
		phase_t                phase;
		logic [GRP_W-1:0]      grp_left;
		logic [LEN_WIDTH-1:0]  acc;
		logic [LEN_WIDTH-1:0]  body_left;
		logic [7:0]            oshift;
		logic [3:0]            ofill;
		logic [31:0]           consumed;
	} dec_state_t;

	typedef struct packed {
		logic [7:0]  decoded_byte;
		logic [3:0]  valid_bits;
		logic        last;
		logic [31:0] total_bits;
		logic        status;
	} result_t;

endpackage

/* rtl/rlpd_step.sv */
module rlpd_step (
	input  rlpd_pkg::dec_state_t cur,
	input  logic [7:0]           stream_byte,
	input  logic                 frame_start,
	input  logic [3:0]           first_bit,
	output rlpd_pkg::dec_state_t nxt,
	output rlpd_pkg::result_t    res0,
	output rlpd_pkg::result_t    res1,
	output logic [1:0]           res_cnt
);
	import rlpd_pkg::*;

	always_comb begin
		dec_state_t           s;
		logic [LEN_WIDTH-1:0] body_base;
		logic [3:0]           taken;
		logic [3:0]           nbits;
		logic [3:0]           res_n [2];
		result_t              r [2];
		logic [1:0]           cnt;
		logic [31:0]          base;
		logic                 b;

		s = cur;
		if (frame_start) begin
			s.phase     = PH_HEADER;
			s.grp_left  = FIRST_GROUP_W;
			s.acc       = '0;
			s.body_left = '0;
			s.oshift    = '0;
			s.ofill     = '0;
			s.consumed  = '0;
		end
		base      = s.consumed;
		body_base = s.body_left;
		taken     = '0;
		nbits     = '0;
		cnt       = '0;
		r[0]      = '0;
		r[1]      = '0;
		res_n[0]  = '0;
		res_n[1]  = '0;

		for (int pos = 0; pos < 8; pos++) begin
			b = stream_byte[3'(7 - pos)];
			if (s.phase != PH_IDLE && !(frame_start && 4'(pos) < first_bit)) begin
				nbits = nbits + 4'd1;
				case (s.phase)
					PH_HEADER: begin
						if (s.grp_left != '0) begin
							s.acc      = {s.acc[LEN_WIDTH-2:0], b};
							s.grp_left = s.grp_left - GRP_W'(1);
						end else if (!b) begin
							if (s.acc > LEN_WIDTH'(LEN_WIDTH)) begin
								r[cnt[0]].last   = 1'b1;
								r[cnt[0]].status = ST_OVERFLOW;
								res_n[cnt[0]]    = nbits;
								cnt              = cnt + 2'd1;
								s.phase          = PH_IDLE;
							end else begin
								s.grp_left = s.acc[GRP_W-1:0];
								s.acc      = '0;
							end
						end else begin
							body_base = s.acc;
							taken     = '0;
							if (s.acc == '0) begin
								r[cnt[0]].last = 1'b1;
								res_n[cnt[0]]  = nbits;
								cnt            = cnt + 2'd1;
								s.phase        = PH_IDLE;
							end else begin
								s.phase = PH_BODY;
							end
						end
					end
					PH_BODY: begin
						s.oshift = {s.oshift[6:0], b};
						s.ofill  = s.ofill + 4'd1;
						taken    = taken + 4'd1;
						if (LEN_WIDTH'(taken) == body_base) begin
							r[cnt[0]].decoded_byte = s.oshift;
							r[cnt[0]].valid_bits   = s.ofill;
							r[cnt[0]].last         = 1'b1;
							res_n[cnt[0]]          = nbits;
							cnt                    = cnt + 2'd1;
							s.phase                = PH_IDLE;
						end else if (s.ofill == BYTE_BITS) begin
							r[cnt[0]].decoded_byte = s.oshift;
							r[cnt[0]].valid_bits   = BYTE_BITS;
							cnt                    = cnt + 2'd1;
							s.oshift               = '0;
							s.ofill                = '0;
						end
					end
					default: ;
				endcase
			end
		end

		for (int k = 0; k < 2; k++) begin
			if (r[k].last)
				r[k].total_bits = base + 32'(res_n[k]);
		end
		s.body_left = body_base - LEN_WIDTH'(taken);
		s.consumed  = base + 32'(nbits);

		nxt     = s;
		res0    = r[0];
		res1    = r[1];
		res_cnt = cnt;
	end

endmodule

/* rtl/rlpd_fifo.sv */
module rlpd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_cnt,
	input  rlpd_pkg::result_t  push0,
	input  rlpd_pkg::result_t  push1,
	output logic               room_two,
	input  logic               pop,
	output logic               not_empty,
	output rlpd_pkg::result_t  head,
	output logic [rlpd_pkg::CNT_W-1:0] level
);
	import rlpd_pkg::*;

	result_t             mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wp_q;
	logic [FIFO_AW-1:0]  rp_q;
	logic [CNT_W-1:0]    cnt_q;

	assign room_two  = cnt_q <= CNT_W'(FIFO_DEPTH - 2);
	assign not_empty = cnt_q != '0;
	assign head      = mem[rp_q];
	assign level     = cnt_q;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem[wp_q] <= push0;
		if (push_cnt == 2'd2)
			mem[wp_q + FIFO_AW'(1)] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + FIFO_AW'(push_cnt);
			rp_q  <= rp_q + FIFO_AW'(pop);
			cnt_q <= cnt_q + CNT_W'(push_cnt) - CNT_W'(pop);
		end
	end

endmodule

/* rtl/recursive_length_prefix_decoder.sv */
// A byte is registered on acceptance and decoded once the result queue has room for two;
// its results are written into that queue, whose head drives the outputs.
// Throughput: one byte per cycle while the result queue has room, set by the eight-bit
// combinational decode step; results are drained through a four-entry result queue.
// Reset (arst_n low, asynchronous): decoder idle, queue empty, offset register zero.
module recursive_length_prefix_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        offset_we,
	input  logic [3:0]  start_bit_offset,
	input  logic        stream_valid,
	output logic        stream_stall,
	input  logic [7:0]  stream_byte,
	input  logic        frame_start,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  decoded_byte,
	output logic [3:0]  valid_bits,
	output logic        last,
	output logic [31:0] total_bits,
	output logic        status
);
	import rlpd_pkg::*;

	logic [3:0]   offset_q;
	logic [3:0]   first_bit;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         start_s1;
	dec_state_t   state_q;
	dec_state_t   state_d;
	result_t      res0;
	result_t      res1;
	result_t      head;
	logic [1:0]   res_cnt;
	logic         room_two;
	logic         process;
	logic         accept;
	logic         pop;
	logic         not_empty;
	logic [CNT_W-1:0] level;

	assign first_bit    = (offset_q > MAX_OFFSET) ? MAX_OFFSET : offset_q;
	assign process      = valid_s1 && room_two;
	assign stream_stall = valid_s1 && !room_two;
	assign accept       = stream_valid && !stream_stall;
	assign pop          = not_empty && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			offset_q <= '0;
		else if (offset_we)
			offset_q <= start_bit_offset;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (process)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= stream_byte;
			start_s1 <= frame_start;
		end
	end

	rlpd_step u_step (
		.cur         (state_q),
		.stream_byte (byte_s1),
		.frame_start (start_s1),
		.first_bit   (first_bit),
		.nxt         (state_d),
		.res0        (res0),
		.res1        (res1),
		.res_cnt     (res_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= PH_IDLE;
			state_q.grp_left  <= '0;
			state_q.acc       <= '0;
			state_q.body_left <= '0;
			state_q.oshift    <= '0;
			state_q.ofill     <= '0;
			state_q.consumed  <= '0;
		end else if (process) begin
			state_q <= state_d;
		end
	end

	rlpd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (process ? res_cnt : 2'd0),
		.push0     (res0),
		.push1     (res1),
		.room_two  (room_two),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head),
		.level     (level)
	);

	assign result_valid = not_empty;
	assign decoded_byte = head.decoded_byte;
	assign valid_bits   = head.valid_bits;
	assign last         = head.last;
	assign total_bits   = head.total_bits;
	assign status       = head.status;

`ifndef ASSERT_OFF
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= CNT_W'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_non_last_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |->
			valid_bits == BYTE_BITS && total_bits == 32'd0 && status == ST_OK)
		else $error("non-final result not a full byte");

	a_overflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_OVERFLOW |->
			last && valid_bits == 4'd0 && decoded_byte == 8'd0)
		else $error("overflow result carries data");

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && level > CNT_W'(FIFO_DEPTH - 2) |-> stream_stall && !process)
		else $error("decode step taken without queue room");
`endif

endmodule

/* tb/decoder_checker.sv */
`timescale 1ns / 1ps

module decoder_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        offset_we,
	input  logic [3:0]  start_bit_offset,
	input  logic        stream_valid,
	input  logic        stream_stall,
	input  logic [7:0]  stream_byte,
	input  logic        frame_start,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [7:0]  decoded_byte,
	input  logic [3:0]  valid_bits,
	input  logic        last,
	input  logic [31:0] total_bits,
	input  logic        status,
	output int          errors,
	output int          outstanding
);
	import rlpd_pkg::*;

	phase_t      ph;
	logic [63:0] grp_left;
	logic [63:0] len_acc;
	logic [63:0] body_left;
	logic [7:0]  out_shift;
	logic [3:0]  out_fill;
	logic [31:0] consumed;
	logic [3:0]  offset_reg;
	result_t     expected_results[$];

	function automatic void expect_result(input logic [7:0] d, input logic [3:0] n,
			input logic l, input logic [31:0] t, input logic s);
		result_t r;
		r.decoded_byte = d;
		r.valid_bits   = n;
		r.last         = l;
		r.total_bits   = t;
		r.status       = s;
		expected_results.push_back(r);
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic fs);
		int   p;
		logic bitv;
		p = 0;
		if (fs) begin
			ph        = PH_HEADER;
			grp_left  = 64'd2;
			len_acc   = '0;
			body_left = '0;
			out_shift = '0;
			out_fill  = '0;
			consumed  = '0;
			p = (offset_reg > MAX_OFFSET) ? int'(MAX_OFFSET) : int'(offset_reg);
		end
		while (p < 8 && ph != PH_IDLE) begin
			bitv     = b[7 - p];
			consumed = consumed + 32'd1;
			if (ph == PH_HEADER) begin
				if (grp_left != 0) begin
					len_acc  = {len_acc[62:0], bitv};
					grp_left = grp_left - 64'd1;
				end else if (!bitv) begin
					if (len_acc > 64'(LEN_WIDTH)) begin
						expect_result(8'd0, 4'd0, 1'b1, consumed, ST_OVERFLOW);
						ph = PH_IDLE;
					end else begin
						grp_left = len_acc;
						len_acc  = '0;
					end
				end else begin
					body_left = len_acc;
					if (body_left == 0) begin
						expect_result(8'd0, 4'd0, 1'b1, consumed, ST_OK);
						ph = PH_IDLE;
					end else begin
						ph = PH_BODY;
					end
				end
			end else begin
				out_shift = {out_shift[6:0], bitv};
				out_fill  = out_fill + 4'd1;
				body_left = body_left - 64'd1;
				if (body_left == 0) begin
					expect_result(out_shift, out_fill, 1'b1, consumed, ST_OK);
					ph = PH_IDLE;
				end else if (out_fill == BYTE_BITS) begin
					expect_result(out_shift, BYTE_BITS, 1'b0, 32'd0, ST_OK);
					out_shift = '0;
					out_fill  = '0;
				end
			end
			p++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			ph          = PH_IDLE;
			grp_left    = '0;
			len_acc     = '0;
			body_left   = '0;
			out_shift   = '0;
			out_fill    = '0;
			consumed    = '0;
			offset_reg  = '0;
			errors      = 0;
			outstanding <= 0;
			expected_results.delete();
		end else begin
			if (offset_we)
				offset_reg = start_bit_offset;
			if (stream_valid && !stream_stall)
				decode_byte(stream_byte, frame_start);
			if (result_valid && !result_stall) begin
				got.decoded_byte = decoded_byte;
				got.valid_bits   = valid_bits;
				got.last         = last;
				got.total_bits   = total_bits;
				got.status       = status;
				if (expected_results.size() == 0) begin
					if (errors < 10)
						$display("[%0t] extra result %02h bits %0d last %0b total %0d st %0b",
							$realtime, got.decoded_byte, got.valid_bits, got.last,
							got.total_bits, got.status);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.decoded_byte !== want.decoded_byte ||
							got.valid_bits !== want.valid_bits ||
							got.last !== want.last || got.total_bits !== want.total_bits ||
							got.status !== want.status) begin
						if (errors < 10) begin
							$display("[%0t] want %02h bits %0d last %0b total %0d st %0b",
								$realtime, want.decoded_byte, want.valid_bits, want.last,
								want.total_bits, want.status);
							$display("[%0t] got  %02h bits %0d last %0b total %0d st %0b",
								$realtime, got.decoded_byte, got.valid_bits, got.last,
								got.total_bits, got.status);
						end
						errors++;
					end
				end
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import rlpd_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        offset_we;
	logic [3:0]  start_bit_offset;
	logic        stream_valid;
	logic        stream_stall;
	logic [7:0]  stream_byte;
	logic        frame_start;
	logic        result_valid;
	logic        result_stall;
	logic [7:0]  decoded_byte;
	logic [3:0]  valid_bits;
	logic        last;
	logic [31:0] total_bits;
	logic        status;
	int          errors;
	int          outstanding;

	bit          frame_bits[$];
	logic [3:0]  cur_offset;
	bit          no_idle;
	int          frame_items;

	recursive_length_prefix_decoder u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.offset_we        (offset_we),
		.start_bit_offset (start_bit_offset),
		.stream_valid     (stream_valid),
		.stream_stall     (stream_stall),
		.stream_byte      (stream_byte),
		.frame_start      (frame_start),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.decoded_byte     (decoded_byte),
		.valid_bits       (valid_bits),
		.last             (last),
		.total_bits       (total_bits),
		.status           (status)
	);

	decoder_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.offset_we        (offset_we),
		.start_bit_offset (start_bit_offset),
		.stream_valid     (stream_valid),
		.stream_stall     (stream_stall),
		.stream_byte      (stream_byte),
		.frame_start      (frame_start),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.decoded_byte     (decoded_byte),
		.valid_bits       (valid_bits),
		.last             (last),
		.total_bits       (total_bits),
		.status           (status),
		.errors           (errors),
		.outstanding      (outstanding)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#(600_000 * 12);
		$display("Test completed with failures");
		$finish;
	end

	// called just after a rising edge; returns at the edge that takes the request
	task automatic send_byte(input logic [7:0] b, input logic fs);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			stream_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream_valid <= 1'b1;
		stream_byte  <= b;
		frame_start  <= fs;
		do @(posedge clk); while (stream_stall);
		frame_items++;
	endtask

	task automatic drain();
		stream_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_offset(input logic [3:0] v);
		drain();
		offset_we        <= 1'b1;
		start_bit_offset <= v;
		cur_offset = v;
		@(posedge clk);
		offset_we <= 1'b0;
	endtask

	function automatic void push_field(input logic [63:0] v, input int w);
		int i;
		for (i = w - 1; i >= 0; i--)
			frame_bits.push_back(v[i]);
	endfunction

	function automatic void open_frame();
		int skip;
		frame_bits.delete();
		skip = (cur_offset > MAX_OFFSET) ? int'(MAX_OFFSET) : int'(cur_offset);
		repeat (skip) frame_bits.push_back(1'($urandom_range(0, 1)));
	endfunction

	// random well-formed header chain, optionally ending in a too-wide group
	function automatic void make_frame(input bit allow_ovf, input int max_body);
		int          width;
		int          groups;
		int          hi;
		logic [63:0] lim;
		logic [63:0] val;
		bit          done;
		open_frame();
		width  = 2;
		groups = 0;
		done   = 1'b0;
		while (!done) begin
			lim = (64'd1 << width) - 64'd1;
			groups++;
			if (groups >= 6 || $urandom_range(0, 2) == 0) begin
				hi  = (lim < 64'(max_body)) ? int'(lim) : max_body;
				val = 64'($urandom_range(0, hi));
				push_field(val, width);
				frame_bits.push_back(1'b1);
				repeat (int'(val)) frame_bits.push_back(1'($urandom_range(0, 1)));
				done = 1'b1;
			end else if (allow_ovf && width >= 6 && $urandom_range(0, 3) == 0) begin
				val = {$urandom, $urandom} & lim;
				if (val <= 64'(LEN_WIDTH))
					val = 64'(LEN_WIDTH + 1);
				push_field(val, width);
				frame_bits.push_back(1'b0);
				done = 1'b1;
			end else begin
				hi  = (lim < 64'(LEN_WIDTH)) ? int'(lim) : LEN_WIDTH;
				if ($urandom_range(0, 1) && hi > 8)
					hi = 8;
				val = 64'($urandom_range(0, hi));
				push_field(val, width);
				frame_bits.push_back(1'b0);
				width = int'(val);
			end
		end
	endfunction

	task automatic send_frame(input int cut, input int trailing);
		int         nbytes;
		int         i;
		int         k;
		logic [7:0] b;
		while (frame_bits.size() % 8 != 0)
			frame_bits.push_back(1'($urandom_range(0, 1)));
		nbytes = frame_bits.size() / 8;
		if (cut > 0 && cut < nbytes)
			nbytes = cut;
		for (i = 0; i < nbytes; i++) begin
			for (k = 0; k < 8; k++)
				b[7 - k] = frame_bits[i * 8 + k];
			send_byte(b, i == 0);
		end
		repeat (trailing) send_byte(8'($urandom), 1'b0);
	endtask

	initial begin : result_sink
		int hold;
		result_stall = 1'b1;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 11);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	initial begin : stimulus
		int phase_no;
		int first_item;
		int sel;
		arst_n           = 1'b0;
		offset_we        = 1'b0;
		start_bit_offset = '0;
		stream_valid     = 1'b0;
		stream_byte      = '0;
		frame_start      = 1'b0;
		cur_offset       = '0;
		no_idle          = 1'b0;
		frame_items      = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		set_offset(4'd0);
		// requests while idle are dropped
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		// empty body
		open_frame(); push_field(0, 2); push_field(1, 1); send_frame(0, 0);
		// short body, then trailing bytes
		open_frame(); push_field(3, 2); push_field(1, 1); push_field(5, 3); send_frame(0, 2);
		// 2 -> 3 -> 7 wide chain, 17 body bits
		open_frame(); push_field(2, 2); push_field(0, 1); push_field(3, 2); push_field(0, 1);
		push_field(7, 3); push_field(0, 1); push_field(17, 7); push_field(1, 1);
		push_field(64'h1_5A3C, 17); send_frame(0, 0);
		// zero-width groups
		open_frame(); push_field(0, 2); push_field(0, 1); push_field(0, 1); push_field(1, 1);
		send_frame(0, 0);
		// overflow by one
		open_frame(); push_field(3, 2); push_field(0, 1); push_field(6, 3); push_field(0, 1);
		push_field(33, 6); push_field(0, 1); send_frame(0, 0);
		// width exactly LEN_WIDTH
		open_frame(); push_field(3, 2); push_field(0, 1); push_field(6, 3); push_field(0, 1);
		push_field(32, 6); push_field(0, 1); push_field(9, 32); push_field(1, 1);
		push_field(64'h1FF, 9); send_frame(0, 0);
		// eight zero bits, then abort mid-header
		open_frame(); push_field(3, 2); push_field(0, 1); push_field(4, 3); push_field(0, 1);
		push_field(8, 4); push_field(1, 1); push_field(0, 8); send_frame(0, 0);
		open_frame(); push_field(3, 2); push_field(0, 1); push_field(5, 3); push_field(0, 1);
		push_field(16, 5); push_field(1, 1); push_field(64'hA5C3, 16); send_frame(1, 0);
		open_frame(); push_field(3, 2); push_field(0, 1); push_field(5, 3); push_field(0, 1);
		push_field(16, 5); push_field(1, 1); push_field(64'hA5C3, 16); send_frame(0, 0);
		// offset saturation and whole-byte skip
		set_offset(4'd15);
		open_frame(); push_field(2, 2); push_field(1, 1); push_field(3, 2); send_frame(0, 0);
		set_offset(4'd8);
		open_frame(); push_field(1, 2); push_field(1, 1); push_field(1, 1); send_frame(0, 0);

		frame_items = 0;
		phase_no    = 0;
		while (frame_items < 1650) begin
			case (phase_no)
				0: set_offset(4'd0);
				1: set_offset(4'd15);
				2: set_offset(4'd8);
				3: set_offset(4'd7);
				default: set_offset(4'($urandom_range(0, 15)));
			endcase
			no_idle    = (phase_no % 3 == 2);
			first_item = frame_items;
			while (frame_items - first_item < 150) begin
				sel = $urandom_range(0, 19);
				if (sel == 0) begin
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
				end else if (sel == 1) begin
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'($urandom));
				end else begin
					make_frame(1'b1, ($urandom_range(0, 9) == 0) ? 300 : 40);
					send_frame((sel == 2) ? $urandom_range(1, 3) : 0,
						(sel < 5) ? $urandom_range(1, 3) : 0);
				end
			end
			phase_no++;
		end

		drain();
		if (errors == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
